// File: hw/rtl/mfep_pkg.sv
package mfep_pkg;

    // Largest meta payload that is captured; longer payloads are skipped
    localparam int unsigned META_KEEP = 4;

    localparam logic [31:0] TAG_MTHD   = 32'h4D54_6864;
    localparam logic [31:0] TAG_MTRK   = 32'h4D54_726B;
    localparam logic [31:0] HDR_LEN    = 32'd6;
    localparam logic [31:0] HDR_FORMAT = 32'd0;
    localparam logic [31:0] HDR_TRACKS = 32'd1;
    localparam logic [7:0]  STATUS_META    = 8'hFF;
    localparam logic [7:0]  META_END_TRACK = 8'h2F;
    localparam logic [3:0]  NIB_PROGRAM  = 4'hC;
    localparam logic [3:0]  NIB_PRESSURE = 4'hD;
    localparam int unsigned DELTA_W = 28;
    localparam int unsigned DELTA_MAX_BYTES = 4;

    typedef enum logic [12:0] {
        PH_TAG    = 13'b0_0000_0000_0001,
        PH_HLEN   = 13'b0_0000_0000_0010,
        PH_FMT    = 13'b0_0000_0000_0100,
        PH_NTRK   = 13'b0_0000_0000_1000,
        PH_DIV    = 13'b0_0000_0001_0000,
        PH_TTAG   = 13'b0_0000_0010_0000,
        PH_TLEN   = 13'b0_0000_0100_0000,
        PH_DELTA  = 13'b0_0000_1000_0000,
        PH_STATUS = 13'b0_0001_0000_0000,
        PH_DATA1  = 13'b0_0010_0000_0000,
        PH_DATA2  = 13'b0_0100_0000_0000,
        PH_META   = 13'b0_1000_0000_0000,
        PH_DONE   = 13'b1_0000_0000_0000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_EVENT  = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TAG       = 3'd1,
        ERR_HDR_LEN   = 3'd2,
        ERR_FORMAT    = 3'd3,
        ERR_TRACKS    = 3'd4,
        ERR_TRACK_TAG = 3'd5,
        ERR_NO_STATUS = 3'd6,
        ERR_FINISHED  = 3'd7
    } err_t;

    typedef struct packed {
        logic [15:0]        ticks_per_qn;
        logic               end_of_track;
        logic               extra_skipped;
        logic [31:0]        meta_bytes;
        logic [7:0]         data2;
        logic [7:0]         data1;
        logic [7:0]         status_byte;
        logic [DELTA_W-1:0] delta_time;
        err_t               error_code;
    } result_t;

endpackage

// File: hw/rtl/midi_file_event_parser.sv
// Channel  Dir  tdata (low bit up)                                  tuser
// s_       in   byte_in[7:0]                                        op
// m_       out  error_code, delta_time, status_byte, data1, data2,  kind
//               meta_bytes, extra_skipped, end_of_track, ticks_per_qn,
//               7 zero pad bits (112 bits total)
// One byte per cycle while the result register is not stalled: a request is held in an
// input register, decoded combinationally against the parser state and written to the result register.
// Each request passes the input register and then the result register; a byte that gives
// no result only updates the state.
// rst_n clears the parser to expect the file header tag; a restart request does the same.
// A stalled result register stalls the input register, which then drops tready.
module midi_file_event_parser
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // byte_in
    input  logic          s_tuser,   // op
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,   // error_code, delta_time, status_byte, data1, data2,
                                     // meta_bytes, extra_skipped, end_of_track, ticks_per_qn
    output logic [1:0]    m_tuser    // kind
);

    localparam int unsigned DW = mfep_pkg::DELTA_W;

    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;
    logic       advance;

    mfep_pkg::phase_t phase_reg, phase_next;
    logic [2:0]    byte_count_reg, byte_count_next;
    logic [31:0]   header_shift_reg, header_shift_next;
    logic [7:0]    running_status_reg, running_status_next;
    logic [DW-1:0] delta_accum_reg, delta_accum_next;
    logic [7:0]    first_data_reg, first_data_next;
    logic [7:0]    second_data_reg, second_data_next;
    logic [7:0]    meta_remaining_reg, meta_remaining_next;
    logic [31:0]   meta_capture_reg, meta_capture_next;
    logic [15:0]   division_reg, division_next;

    logic               res_valid;
    mfep_pkg::kind_t    res_kind;
    mfep_pkg::result_t  res;
    logic               out_valid_reg;
    mfep_pkg::kind_t    out_kind_reg;
    mfep_pkg::result_t  out_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    always_comb
    begin
        logic [7:0]    b;
        logic [31:0]   shifted;
        logic [2:0]    cnt;
        logic [2:0]    need;
        logic          hdr_done;
        logic          do_after_first;
        logic          do_finish;
        logic          do_emit;
        logic          is_meta;
        logic [7:0]    idx;
        logic [7:0]    rem;
        logic [31:0]   cap;

        b              = in_byte_reg;
        shifted        = {header_shift_reg[23:0], b};
        cnt            = byte_count_reg + 3'd1;
        need           = 3'd4;
        hdr_done       = 1'b0;
        do_after_first = 1'b0;
        do_finish      = 1'b0;
        do_emit        = 1'b0;
        is_meta        = 1'b0;
        idx            = second_data_reg - meta_remaining_reg;
        rem            = meta_remaining_reg - 8'd1;
        cap            = meta_capture_reg;

        phase_next          = phase_reg;
        byte_count_next     = byte_count_reg;
        header_shift_next   = header_shift_reg;
        running_status_next = running_status_reg;
        delta_accum_next    = delta_accum_reg;
        first_data_next     = first_data_reg;
        second_data_next    = second_data_reg;
        meta_remaining_next = meta_remaining_reg;
        meta_capture_next   = meta_capture_reg;
        division_next       = division_reg;

        res_valid = 1'b0;
        res_kind  = mfep_pkg::KIND_ERROR;
        res       = '0;

        if (phase_reg == mfep_pkg::PH_FMT || phase_reg == mfep_pkg::PH_NTRK
            || phase_reg == mfep_pkg::PH_DIV)
        begin
            need = 3'd2;
        end

        if (in_op_reg)
        begin
            // restart: back to the reset state, no result
            phase_next          = mfep_pkg::PH_TAG;
            byte_count_next     = '0;
            header_shift_next   = '0;
            running_status_next = '0;
            delta_accum_next    = '0;
            first_data_next     = '0;
            second_data_next    = '0;
            meta_remaining_next = '0;
            meta_capture_next   = '0;
            division_next       = '0;
        end
        else
        begin
            unique case (phase_reg)
                mfep_pkg::PH_TAG, mfep_pkg::PH_HLEN, mfep_pkg::PH_FMT,
                mfep_pkg::PH_NTRK, mfep_pkg::PH_DIV, mfep_pkg::PH_TTAG,
                mfep_pkg::PH_TLEN:
                begin
                    header_shift_next = shifted;
                    byte_count_next   = cnt;
                    if (cnt >= need)
                    begin
                        hdr_done          = 1'b1;
                        header_shift_next = '0;
                        byte_count_next   = '0;
                    end
                end
                mfep_pkg::PH_DELTA:
                begin
                    delta_accum_next = {delta_accum_reg[DW-8:0], b[6:0]};
                    byte_count_next  = cnt;
                    if (!b[7] || cnt >= 3'(mfep_pkg::DELTA_MAX_BYTES))
                    begin
                        byte_count_next = '0;
                        phase_next      = mfep_pkg::PH_STATUS;
                    end
                end
                mfep_pkg::PH_STATUS:
                begin
                    if (b[7])
                    begin
                        running_status_next = b;
                        phase_next          = mfep_pkg::PH_DATA1;
                    end
                    else
                    begin
                        first_data_next = b;
                        do_after_first  = 1'b1;
                    end
                end
                mfep_pkg::PH_DATA1:
                begin
                    first_data_next = b;
                    do_after_first  = 1'b1;
                end
                mfep_pkg::PH_DATA2:
                begin
                    second_data_next = b;
                    do_finish        = 1'b1;
                end
                mfep_pkg::PH_META:
                begin
                    if (second_data_reg <= 8'(mfep_pkg::META_KEEP) && idx < 8'd4)
                    begin
                        unique case (idx[1:0])
                            2'd0: cap[31:24] = cap[31:24] | b;
                            2'd1: cap[23:16] = cap[23:16] | b;
                            2'd2: cap[15:8]  = cap[15:8]  | b;
                            2'd3: cap[7:0]   = cap[7:0]   | b;
                            default: cap = meta_capture_reg;
                        endcase
                    end
                    meta_capture_next   = cap;
                    meta_remaining_next = rem;
                    if (rem == 8'd0)
                    begin
                        do_emit = 1'b1;
                    end
                end
                mfep_pkg::PH_DONE:
                begin
                    res_valid      = 1'b1;
                    res.error_code = mfep_pkg::ERR_FINISHED;
                end
                default:
                begin
                    res_valid      = 1'b1;
                    res.error_code = mfep_pkg::ERR_FINISHED;
                end
            endcase

            if (hdr_done)
            begin
                priority case (phase_reg)
                    mfep_pkg::PH_TAG:
                        if (shifted != mfep_pkg::TAG_MTHD)
                        begin
                            res_valid = 1'b1;
                            res.error_code = mfep_pkg::ERR_TAG;
                        end
                        else phase_next = mfep_pkg::PH_HLEN;
                    mfep_pkg::PH_HLEN:
                        if (shifted != mfep_pkg::HDR_LEN)
                        begin
                            res_valid = 1'b1;
                            res.error_code = mfep_pkg::ERR_HDR_LEN;
                        end
                        else phase_next = mfep_pkg::PH_FMT;
                    mfep_pkg::PH_FMT:
                        if (shifted != mfep_pkg::HDR_FORMAT)
                        begin
                            res_valid = 1'b1;
                            res.error_code = mfep_pkg::ERR_FORMAT;
                        end
                        else phase_next = mfep_pkg::PH_NTRK;
                    mfep_pkg::PH_NTRK:
                        if (shifted != mfep_pkg::HDR_TRACKS)
                        begin
                            res_valid = 1'b1;
                            res.error_code = mfep_pkg::ERR_TRACKS;
                        end
                        else phase_next = mfep_pkg::PH_DIV;
                    mfep_pkg::PH_DIV:
                    begin
                        division_next = shifted[15:0];
                        phase_next    = mfep_pkg::PH_TTAG;
                    end
                    mfep_pkg::PH_TTAG:
                        if (shifted != mfep_pkg::TAG_MTRK)
                        begin
                            res_valid = 1'b1;
                            res.error_code = mfep_pkg::ERR_TRACK_TAG;
                        end
                        else phase_next = mfep_pkg::PH_TLEN;
                    default:
                    begin
                        // track length: an empty track ends at once
                        res_valid        = 1'b1;
                        res_kind         = mfep_pkg::KIND_HEADER;
                        res.end_of_track = (shifted == 32'd0);
                        res.ticks_per_qn = division_reg;
                        delta_accum_next = '0;
                        phase_next = (shifted == 32'd0) ? mfep_pkg::PH_DONE
                                                        : mfep_pkg::PH_DELTA;
                    end
                endcase
                if (res_valid && res_kind == mfep_pkg::KIND_ERROR)
                begin
                    phase_next = mfep_pkg::PH_DONE;
                end
            end

            if (do_after_first)
            begin
                if (running_status_reg[7:4] == mfep_pkg::NIB_PROGRAM
                    || running_status_reg[7:4] == mfep_pkg::NIB_PRESSURE)
                begin
                    second_data_next = '0;
                    do_finish        = 1'b1;
                end
                else
                begin
                    phase_next = mfep_pkg::PH_DATA2;
                end
            end

            if (do_finish)
            begin
                if (!running_status_reg[7])
                begin
                    res_valid      = 1'b1;
                    res.error_code = mfep_pkg::ERR_NO_STATUS;
                    phase_next     = mfep_pkg::PH_DONE;
                end
                else if (running_status_reg == mfep_pkg::STATUS_META)
                begin
                    meta_remaining_next = second_data_next;
                    meta_capture_next   = '0;
                    cap                 = '0;
                    if (second_data_next == 8'd0)
                    begin
                        do_emit = 1'b1;
                    end
                    else
                    begin
                        phase_next = mfep_pkg::PH_META;
                    end
                end
                else
                begin
                    do_emit = 1'b1;
                end
            end

            if (do_emit)
            begin
                is_meta = (running_status_reg == mfep_pkg::STATUS_META);
                res_valid         = 1'b1;
                res_kind          = mfep_pkg::KIND_EVENT;
                res.delta_time    = delta_accum_reg;
                res.status_byte   = running_status_reg;
                res.data1         = first_data_next;
                res.data2         = second_data_next;
                res.extra_skipped = is_meta
                                    && second_data_next > 8'(mfep_pkg::META_KEEP);
                res.meta_bytes    = (is_meta && !res.extra_skipped) ? cap : 32'd0;
                res.end_of_track  = is_meta
                                    && first_data_next == mfep_pkg::META_END_TRACK
                                    && second_data_next == 8'd0;
                delta_accum_next  = '0;
                byte_count_next   = '0;
                meta_capture_next = '0;
                phase_next = res.end_of_track ? mfep_pkg::PH_DONE : mfep_pkg::PH_DELTA;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= mfep_pkg::PH_TAG;
            byte_count_reg     <= '0;
            header_shift_reg   <= '0;
            running_status_reg <= '0;
            delta_accum_reg    <= '0;
            first_data_reg     <= '0;
            second_data_reg    <= '0;
            meta_remaining_reg <= '0;
            meta_capture_reg   <= '0;
            division_reg       <= '0;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            byte_count_reg     <= byte_count_next;
            header_shift_reg   <= header_shift_next;
            running_status_reg <= running_status_next;
            delta_accum_reg    <= delta_accum_next;
            first_data_reg     <= first_data_next;
            second_data_reg    <= second_data_next;
            meta_remaining_reg <= meta_remaining_next;
            meta_capture_reg   <= meta_capture_next;
            division_reg       <= division_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_kind_reg <= res_kind;
            out_reg      <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {7'd0, out_reg};

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    import mfep_pkg::*;

    // Tracks the parser state from the accepted byte requests and holds the results
    // each one should produce, oldest first.
    class smf_result_board;
        phase_t             phase;
        int unsigned        byte_idx;
        logic [31:0]        hdr_shift;
        logic [7:0]         run_status;
        logic [DELTA_W-1:0] delta_acc;
        logic [7:0]         data_a;
        logic [7:0]         data_b;
        logic [7:0]         meta_left;
        logic [31:0]        meta_word;
        logic [15:0]        division;
        bit                 track_ended;
        bit                 parse_failed;

        result_t            pending_results[$];
        kind_t              pending_kinds[$];
        int                 mismatches;
        int                 n_header;
        int                 n_event;
        int                 n_error;

        function new();
            mismatches = 0;
            n_header   = 0;
            n_event    = 0;
            n_error    = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase        = PH_TAG;
            byte_idx     = 0;
            hdr_shift    = '0;
            run_status   = '0;
            delta_acc    = '0;
            data_a       = '0;
            data_b       = '0;
            meta_left    = '0;
            meta_word    = '0;
            division     = '0;
            track_ended  = 1'b0;
            parse_failed = 1'b0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void push(kind_t k, result_t r);
            pending_kinds.push_back(k);
            pending_results.push_back(r);
        endfunction

        function void push_error(err_t code);
            result_t r;
            r            = '0;
            r.error_code = code;
            parse_failed = 1'b1;
            phase        = PH_DONE;
            push(KIND_ERROR, r);
        endfunction

        function void emit_event();
            result_t r;
            r             = '0;
            r.delta_time  = delta_acc;
            r.status_byte = run_status;
            r.data1       = data_a;
            r.data2       = data_b;
            if (run_status == STATUS_META)
            begin
                r.extra_skipped = (data_b > META_KEEP);
                r.meta_bytes    = r.extra_skipped ? 32'd0 : meta_word;
                if (data_a == META_END_TRACK && data_b == 8'd0)
                begin
                    r.end_of_track = 1'b1;
                    track_ended    = 1'b1;
                end
            end
            push(KIND_EVENT, r);
            delta_acc = '0;
            byte_idx  = 0;
            meta_word = '0;
            phase     = r.end_of_track ? PH_DONE : PH_DELTA;
        endfunction

        function void finish_message();
            if (!run_status[7])
            begin
                push_error(ERR_NO_STATUS);
                return;
            end
            if (run_status == STATUS_META)
            begin
                meta_left = data_b;
                meta_word = '0;
                if (meta_left == 8'd0)
                    emit_event();
                else
                    phase = PH_META;
            end
            else
                emit_event();
        endfunction

        function void after_first();
            if (run_status[7:4] == NIB_PROGRAM || run_status[7:4] == NIB_PRESSURE)
            begin
                data_b = 8'd0;
                finish_message();
            end
            else
                phase = PH_DATA2;
        endfunction

        function void note_request(logic op, logic [7:0] b);
            int unsigned need;
            logic [31:0] v;
            logic [7:0]  idx;
            int          shift;
            result_t     r;
            if (op)
            begin
                clear_state();
                return;
            end
            if (phase == PH_DONE || track_ended || parse_failed)
            begin
                push_error(ERR_FINISHED);
                return;
            end
            case (phase)
                PH_TAG, PH_HLEN, PH_FMT, PH_NTRK, PH_DIV, PH_TTAG, PH_TLEN:
                begin
                    need      = (phase == PH_FMT || phase == PH_NTRK || phase == PH_DIV) ? 2 : 4;
                    hdr_shift = {hdr_shift[23:0], b};
                    byte_idx  = (byte_idx + 1) & 7;
                    if (byte_idx >= need)
                    begin
                        v         = hdr_shift;
                        hdr_shift = '0;
                        byte_idx  = 0;
                        case (phase)
                            PH_TAG:
                                if (v != TAG_MTHD) push_error(ERR_TAG);
                                else phase = PH_HLEN;
                            PH_HLEN:
                                if (v != HDR_LEN) push_error(ERR_HDR_LEN);
                                else phase = PH_FMT;
                            PH_FMT:
                                if (v != HDR_FORMAT) push_error(ERR_FORMAT);
                                else phase = PH_NTRK;
                            PH_NTRK:
                                if (v != HDR_TRACKS) push_error(ERR_TRACKS);
                                else phase = PH_DIV;
                            PH_DIV:
                            begin
                                division = v[15:0];
                                phase    = PH_TTAG;
                            end
                            PH_TTAG:
                                if (v != TAG_MTRK) push_error(ERR_TRACK_TAG);
                                else phase = PH_TLEN;
                            default:
                            begin
                                // a zero-length track is over as soon as the header is
                                if (v == 32'd0)
                                begin
                                    track_ended = 1'b1;
                                    phase       = PH_DONE;
                                end
                                else
                                    phase = PH_DELTA;
                                delta_acc      = '0;
                                r              = '0;
                                r.end_of_track = track_ended;
                                r.ticks_per_qn = division;
                                push(KIND_HEADER, r);
                            end
                        endcase
                    end
                end
                PH_DELTA:
                begin
                    delta_acc = {delta_acc[DELTA_W-8:0], b[6:0]};
                    byte_idx  = (byte_idx + 1) & 7;
                    // the fourth byte closes the delta whatever its top bit says
                    if (!b[7] || byte_idx >= DELTA_MAX_BYTES)
                    begin
                        byte_idx = 0;
                        phase    = PH_STATUS;
                    end
                end
                PH_STATUS:
                begin
                    if (b[7])
                    begin
                        run_status = b;
                        phase      = PH_DATA1;
                    end
                    else
                    begin
                        data_a = b;
                        after_first();
                    end
                end
                PH_DATA1:
                begin
                    data_a = b;
                    after_first();
                end
                PH_DATA2:
                begin
                    data_b = b;
                    finish_message();
                end
                PH_META:
                begin
                    idx = data_b - meta_left;
                    if (data_b <= META_KEEP && idx < 8'd4)
                    begin
                        shift     = 24 - 8 * int'(idx);
                        meta_word = meta_word | (32'(b) << shift);
                    end
                    meta_left = meta_left - 8'd1;
                    if (meta_left == 8'd0)
                        emit_event();
                end
                default:
                    push_error(ERR_FINISHED);
            endcase
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [1:0] kind, result_t got);
            result_t want;
            kind_t   want_kind;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing pending: kind %0d", kind);
                mismatches++;
                return;
            end
            want      = pending_results.pop_front();
            want_kind = pending_kinds.pop_front();
            if (want_kind == KIND_HEADER)
                n_header++;
            else if (want_kind == KIND_EVENT)
                n_event++;
            else
                n_error++;
            compare("kind", want_kind, kind);
            compare("error_code", want.error_code, got.error_code);
            compare("delta_time", want.delta_time, got.delta_time);
            compare("status_byte", want.status_byte, got.status_byte);
            compare("data1", want.data1, got.data1);
            compare("data2", want.data2, got.data2);
            compare("meta_bytes", want.meta_bytes, got.meta_bytes);
            compare("extra_skipped", want.extra_skipped, got.extra_skipped);
            compare("end_of_track", want.end_of_track, got.end_of_track);
            compare("ticks_per_qn", want.ticks_per_qn, got.ticks_per_qn);
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n;
    logic           s_tvalid;
    logic           s_tready;
    logic [7:0]     s_tdata;
    logic           s_tuser;
    logic           m_tvalid;
    logic           m_tready;
    logic [111:0]   m_tdata;
    logic [1:0]     m_tuser;

    smf_result_board board;
    bit              idle_on;
    bit              stall_on;
    int              n_requests;
    int              n_files;
    logic [7:0]      file_bytes[$];
    logic [7:0]      last_status;

    midi_file_event_parser u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.note_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                board.check_result(m_tuser, m_tdata[104:0]);
        end
    end

    // Result side: stall in bursts while enabled
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (stall_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic put_request(logic op, logic [7:0] b);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        n_requests++;
    endtask

    task automatic send_bytes();
        foreach (file_bytes[i])
            put_request(1'b0, file_bytes[i]);
        file_bytes.delete();
    endtask

    // Hold off the sender until every pending result is out
    task automatic drain();
        s_tvalid <= 1'b0;
        // let the scoreboard take the last accepted request first
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic void add_word(logic [31:0] w, int n);
        for (int i = n - 1; i >= 0; i--)
            file_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic void add_header(logic [15:0] div, logic [31:0] trk_len);
        add_word(TAG_MTHD, 4);
        add_word(HDR_LEN, 4);
        add_word(HDR_FORMAT, 2);
        add_word(HDR_TRACKS, 2);
        add_word({16'd0, div}, 2);
        add_word(TAG_MTRK, 4);
        add_word(trk_len, 4);
    endfunction

    function automatic void add_delta();
        int n;
        case ($urandom_range(0, 7))
            0: file_bytes.push_back(8'h00);
            1: add_word(32'hFFFF_FF7F, 4);
            // four continuation bytes: the delta closes anyway
            2: add_word(32'h8080_8080, 4);
            3: repeat (4) file_bytes.push_back(8'($urandom_range(128, 255)));
            default:
            begin
                n = $urandom_range(1, 4);
                repeat (n - 1) file_bytes.push_back(8'($urandom_range(128, 255)));
                file_bytes.push_back(8'($urandom_range(0, 127)));
            end
        endcase
    endfunction

    // Running status needs a first byte below 0x80, or it reads as a new status.
    function automatic void add_body(logic [7:0] st, bit running);
        int         len;
        logic [7:0] mtype;
        if (st == STATUS_META)
        begin
            mtype = ($urandom_range(0, 7) == 0) ? META_END_TRACK
                                                : 8'($urandom_range(0, running ? 127 : 255));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(0, META_KEEP);
                6, 7, 8:          len = $urandom_range(META_KEEP + 1, 12);
                default:          len = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(13, 40);
            endcase
            file_bytes.push_back(mtype);
            file_bytes.push_back(8'(len));
            repeat (len) file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            file_bytes.push_back(8'($urandom_range(0, running ? 127 : 255)));
            if (st[7:4] != NIB_PROGRAM && st[7:4] != NIB_PRESSURE)
                file_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void add_event();
        logic [7:0] st;
        add_delta();
        if (last_status != 8'h00 && $urandom_range(0, 3) == 0)
            add_body(last_status, 1'b1);
        else
        begin
            st = ($urandom_range(0, 3) == 0) ? STATUS_META : 8'($urandom_range(128, 254));
            file_bytes.push_back(st);
            last_status = st;
            add_body(st, 1'b0);
        end
    endfunction

    task automatic run_file();
        int          pick;
        int          idx;
        logic [15:0] div;
        logic [31:0] trk_len;
        pick        = $urandom_range(0, 7);
        last_status = 8'h00;
        n_files++;
        put_request(1'b1, 8'($urandom_range(0, 255)));
        if (pick == 0)
            repeat ($urandom_range(1, 8)) file_bytes.push_back(8'($urandom_range(0, 255)));
        else
        begin
            case ($urandom_range(0, 5))
                0:       div = 16'h0000;
                1:       div = 16'hFFFF;
                default: div = 16'($urandom_range(0, 65535));
            endcase
            trk_len = ($urandom_range(0, 15) == 0) ? 32'd0 : 32'($urandom());
            add_header(div, trk_len);
            // flip one bit in the first header bytes, up to the track tag; the division among them is not checked
            if (pick == 1)
            begin
                idx             = $urandom_range(0, 17);
                file_bytes[idx] = file_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            // data before any status byte
            if (pick == 2)
            begin
                file_bytes.push_back(8'h00);
                file_bytes.push_back(8'($urandom_range(0, 127)));
                file_bytes.push_back(8'($urandom_range(0, 255)));
            end
            repeat ($urandom_range(1, 6)) add_event();
            if ($urandom_range(0, 3) != 0)
            begin
                add_delta();
                file_bytes.push_back(STATUS_META);
                file_bytes.push_back(META_END_TRACK);
                file_bytes.push_back(8'h00);
            end
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        send_bytes();
    endtask

    initial
    begin
        int drains;
        board      = new();
        drains     = 0;
        n_requests = 0;
        n_files    = 0;
        idle_on    = 1'b0;
        stall_on   = 1'b0;
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tuser    <= 1'b0;
        s_tdata    <= 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bad file tag, then a byte after the error
        add_word(TAG_MTHD ^ 32'h1, 4);
        file_bytes.push_back(8'hFF);
        send_bytes();
        put_request(1'b1, 8'h00);
        // widest time base with an empty track, then a byte past the end
        add_header(16'hFFFF, 32'd0);
        file_bytes.push_back(8'h00);
        send_bytes();

        while (n_requests < 550)
        begin
            if (n_requests > 470)
            begin
                idle_on  = 1'b0;
                stall_on = 1'b0;
            end
            else
            begin
                idle_on  = ($urandom_range(0, 3) != 0);
                stall_on = ($urandom_range(0, 3) != 0);
            end
            run_file();
            if (drains == 0 || $urandom_range(0, 5) == 0)
            begin
                drain();
                drains++;
            end
        end

        drain();
        $display("Sent %0d byte requests over %0d files; checked %0d headers, %0d events,",
                 n_requests, n_files, board.n_header, board.n_event);
        $display("and %0d error results", board.n_error);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("Timeout: results still pending");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: midi_file_event_parser.f
hw/rtl/mfep_pkg.sv
hw/rtl/midi_file_event_parser.sv
dv/tb.sv
